// ----- rtl/rgb_color_histogram_3d_macros.svh -----
// Assertion helpers for the histogram RTL.
`ifndef RGB_COLOR_HISTOGRAM_3D_MACROS_SVH
`define RGB_COLOR_HISTOGRAM_3D_MACROS_SVH

// Check a condition that must hold in the same cycle.
`define RCH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check a condition that must hold in the next cycle.
`define RCH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rch_pkg.sv -----
`default_nettype none

package rch_pkg;

	localparam int BINS_PER_CHANNEL_DEF = 16;
	localparam int COUNT_BITS_DEF       = 32;

	localparam int CHANNEL_BITS    = 8;
	localparam int SEL_BITS        = 12;
	// widest bin index over the whole parameter range (32^3 bins)
	localparam int IDX_MAX_BITS    = 15;
	localparam int COUNT_OUT_BITS  = 32;

	localparam int CMD_QUEUE_DEPTH = 4;
	localparam int RES_QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		OP_ACC,   // bump one bin
		OP_READ,  // return one bin and clear it
		OP_SKIP   // read past the store: return zero, touch nothing
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic [IDX_MAX_BITS-1:0] addr;
	} cmd_t;

	typedef struct packed {
		logic [SEL_BITS-1:0]       bin_number;
		logic [COUNT_OUT_BITS-1:0] bin_count;
	} res_t;

endpackage

`default_nettype wire

// ----- rtl/rch_fifo.sv -----
`default_nettype none

module rch_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = rch_pkg::CMD_QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             din,
	output logic                         full,
	input  logic                         pop,
	output logic [WIDTH-1:0]             dout,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    slot_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign dout    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rch_front.sv -----
`default_nettype none

module rch_front #(
	parameter int BINS_PER_CHANNEL = rch_pkg::BINS_PER_CHANNEL_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              func,
	input  logic [rch_pkg::CHANNEL_BITS-1:0]  blue,
	input  logic [rch_pkg::CHANNEL_BITS-1:0]  green,
	input  logic [rch_pkg::CHANNEL_BITS-1:0]  red,
	input  logic [rch_pkg::SEL_BITS-1:0]      bin_select,
	input  logic                              clr_busy,
	input  logic                              q_full,
	output logic                              q_push,
	output rch_pkg::cmd_t                     cmd
);

	import rch_pkg::*;

	localparam int BW       = 256 / BINS_PER_CHANNEL;
	localparam int RECIP    = (65536 + BW - 1) / BW;
	localparam int CH_BITS  = $clog2(BINS_PER_CHANNEL);
	localparam int DEPTH    = BINS_PER_CHANNEL * BINS_PER_CHANNEL * BINS_PER_CHANNEL;
	localparam int PROD_BITS = 25;

	// quantize by reciprocal; exact for 8-bit inputs and bin widths up to 128
	function automatic logic [CH_BITS-1:0] quant(input logic [CHANNEL_BITS-1:0] v);
		logic [PROD_BITS-1:0] prod;
		logic [7:0]           q;
		prod = PROD_BITS'(v) * PROD_BITS'(RECIP);
		q    = prod[23:16];
		if (q > 8'(BINS_PER_CHANNEL - 1)) begin
			return CH_BITS'(BINS_PER_CHANNEL - 1);
		end
		return q[CH_BITS-1:0];
	endfunction

	logic                  advance;
	logic                  accept;
	logic                  valid_s1;
	logic                  func_s1;
	logic [CH_BITS-1:0]    bb_s1;
	logic [CH_BITS-1:0]    gb_s1;
	logic [CH_BITS-1:0]    rb_s1;
	logic [SEL_BITS-1:0]   sel_s1;
	logic                  valid_s2;
	cmd_t                  cmd_s2;
	logic [31:0]           idx;
	cmd_t                  cmd_next;

	// hold both stages while the queue is full
	assign advance = !(valid_s2 && q_full);
	assign full    = clr_busy || !advance;
	assign accept  = push && !full;
	assign q_push  = valid_s2 && !q_full;
	assign cmd     = cmd_s2;

	always_comb begin
		idx = 32'(bb_s1) * 32'(BINS_PER_CHANNEL * BINS_PER_CHANNEL)
			+ 32'(gb_s1) * 32'(BINS_PER_CHANNEL) + 32'(rb_s1);
		if (func_s1) begin
			cmd_next.addr = IDX_MAX_BITS'(sel_s1);
			cmd_next.op   = (32'(sel_s1) >= 32'(DEPTH)) ? OP_SKIP : OP_READ;
		end else begin
			cmd_next.addr = IDX_MAX_BITS'(idx);
			cmd_next.op   = OP_ACC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			func_s1 <= func;
			bb_s1   <= quant(blue);
			gb_s1   <= quant(green);
			rb_s1   <= quant(red);
			sel_s1  <= bin_select;
			cmd_s2  <= cmd_next;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rch_back.sv -----
`default_nettype none

module rch_back #(
	parameter int BINS_PER_CHANNEL = rch_pkg::BINS_PER_CHANNEL_DEF,
	parameter int COUNT_BITS       = rch_pkg::COUNT_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cmd_empty,
	input  rch_pkg::cmd_t                             cmd,
	output logic                                      cmd_pop,
	input  logic [$clog2(rch_pkg::RES_QUEUE_DEPTH+1)-1:0] res_count,
	output logic                                      res_push,
	output rch_pkg::res_t                             res,
	output logic                                      clr_busy
);

	import rch_pkg::*;

	localparam int DEPTH   = BINS_PER_CHANNEL * BINS_PER_CHANNEL * BINS_PER_CHANNEL;
	localparam int AW      = $clog2(DEPTH);
	localparam int RC_BITS = $clog2(RES_QUEUE_DEPTH + 1);

	logic [COUNT_BITS-1:0]   bin_mem [DEPTH];
	logic                    clr_busy_q;
	logic [AW-1:0]           clr_addr_q;

	logic                    issue;
	logic                    room;
	logic                    valid_s1;
	op_t                     op_s1;
	logic [IDX_MAX_BITS-1:0] addr_s1;
	logic [COUNT_BITS-1:0]   rd_data_s1;
	logic                    fwd_s1;
	logic [COUNT_BITS-1:0]   fwd_data_s1;

	logic [COUNT_BITS-1:0]   old_count;
	logic                    wr_s1;
	logic [COUNT_BITS-1:0]   wdata_s1;
	logic                    res_s1;
	logic [COUNT_BITS-1:0]   rcount_s1;

	logic                    mem_we;
	logic [AW-1:0]           mem_wa;
	logic [COUNT_BITS-1:0]   mem_wd;

	// keep a slot free for the result still in flight
	assign room     = ({1'b0, res_count} + (RC_BITS+1)'(res_s1)) < (RC_BITS+1)'(RES_QUEUE_DEPTH);
	assign issue    = !cmd_empty && !clr_busy_q && room;
	assign cmd_pop  = issue;
	assign clr_busy = clr_busy_q;

	// take the count just written by the previous item on the same bin
	assign old_count = fwd_s1 ? fwd_data_s1 : rd_data_s1;

	always_comb begin
		wr_s1     = 1'b0;
		wdata_s1  = '0;
		res_s1    = 1'b0;
		rcount_s1 = '0;
		case (op_s1)
			OP_ACC: begin
				wr_s1    = valid_s1;
				wdata_s1 = (&old_count) ? old_count : old_count + 1'b1;
			end
			OP_READ: begin
				wr_s1     = valid_s1;
				res_s1    = valid_s1;
				rcount_s1 = old_count;
			end
			OP_SKIP: begin
				res_s1 = valid_s1;
			end
			default: begin
				wr_s1 = 1'b0;
			end
		endcase
	end

	assign res_push       = res_s1;
	assign res.bin_number = addr_s1[SEL_BITS-1:0];
	assign res.bin_count  = COUNT_OUT_BITS'(rcount_s1);

	assign mem_we = clr_busy_q || wr_s1;
	assign mem_wa = clr_busy_q ? clr_addr_q : addr_s1[AW-1:0];
	assign mem_wd = clr_busy_q ? '0 : wdata_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			valid_s1 <= issue;
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			op_s1       <= cmd.op;
			addr_s1     <= cmd.addr;
			fwd_s1      <= wr_s1 && (addr_s1 == cmd.addr);
			fwd_data_s1 <= wdata_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && cmd.op != OP_SKIP) begin
			rd_data_s1 <= bin_mem[cmd.addr[AW-1:0]];
		end
		if (mem_we) begin
			bin_mem[mem_wa] <= mem_wd;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rgb_color_histogram_3d.sv -----
// Channel   Handshake       Fields
// request   push / full     func, blue, green, red, bin_select
// result    pop / empty     bin_number, bin_count
//
// Accumulate and read requests share the store's single read-modify-write
// slot, so one request per cycle streams through while the result queue has
// room; back to back hits on one bin are forwarded. After reset a clearing
// pass writes zero over the whole store, one bin per cycle
// (BINS_PER_CHANNEL^3 bins, 4096 by default), and full stays high until it
// ends. A stalled result queue stalls only the back end; the front keeps
// taking requests until the command queue fills.

`default_nettype none

`include "rgb_color_histogram_3d_macros.svh"

module rgb_color_histogram_3d #(
	parameter int BINS_PER_CHANNEL = rch_pkg::BINS_PER_CHANNEL_DEF,
	parameter int COUNT_BITS       = rch_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic                                func,
	input  logic [rch_pkg::CHANNEL_BITS-1:0]    blue,
	input  logic [rch_pkg::CHANNEL_BITS-1:0]    green,
	input  logic [rch_pkg::CHANNEL_BITS-1:0]    red,
	input  logic [rch_pkg::SEL_BITS-1:0]        bin_select,
	output logic                                empty,
	input  logic                                pop,
	output logic [rch_pkg::SEL_BITS-1:0]        bin_number,
	output logic [rch_pkg::COUNT_OUT_BITS-1:0]  bin_count
);

	import rch_pkg::*;

	localparam int CMD_W   = $bits(cmd_t);
	localparam int RES_W   = $bits(res_t);
	localparam int RC_BITS = $clog2(RES_QUEUE_DEPTH + 1);

	// front end to command queue
	logic               cmd_push;
	logic               cmd_full;
	cmd_t               cmd_in;
	// command queue to back end
	logic               cmd_empty;
	logic               cmd_pop;
	logic [CMD_W-1:0]   cmd_bits;
	cmd_t               cmd_head;
	// back end to result queue
	logic               res_push;
	logic               res_full;
	res_t               res_in;
	logic [RC_BITS-1:0] res_count;
	logic [RES_W-1:0]   res_bits;
	res_t               res_head;
	logic               clr_busy;

	// Classify the request and compute the bin index.
	rch_front #(
		.BINS_PER_CHANNEL(BINS_PER_CHANNEL)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.func       (func),
		.blue       (blue),
		.green      (green),
		.red        (red),
		.bin_select (bin_select),
		.clr_busy   (clr_busy),
		.q_full     (cmd_full),
		.q_push     (cmd_push),
		.cmd        (cmd_in)
	);

	// Decouple the front end from the store.
	rch_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(CMD_QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_bits),
		.empty  (cmd_empty),
		.count  ()
	);

	assign cmd_head = cmd_t'(cmd_bits);

	// Update the bin store and produce read results.
	rch_back #(
		.BINS_PER_CHANNEL(BINS_PER_CHANNEL),
		.COUNT_BITS      (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.res_count (res_count),
		.res_push  (res_push),
		.res       (res_in),
		.clr_busy  (clr_busy)
	);

	// Hold results until the consumer pops them.
	rch_fifo #(
		.WIDTH(RES_W),
		.DEPTH(RES_QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_bits),
		.empty  (empty),
		.count  (res_count)
	);

	assign res_head   = res_t'(res_bits);
	assign bin_number = res_head.bin_number;
	assign bin_count  = res_head.bin_count;

	`RCH_ASSERT_IMPL(a_clear_blocks_requests, clk, arst_n, clr_busy, full, "request taken during clear")
	`RCH_ASSERT_IMPL(a_cmd_q_no_overflow, clk, arst_n, cmd_push, !cmd_full, "command queue overflow")
	`RCH_ASSERT_IMPL(a_res_q_no_overflow, clk, arst_n, res_push, !res_full, "result queue overflow")
	`RCH_ASSERT_NEXT(a_result_visible, clk, arst_n, res_push, !empty, "result lost after push")

endmodule

`default_nettype wire
